// ----- rtl/core/sprite_row_rle_decoder_defines.svh -----
// Assertion macros for the sprite row run-length decoder checkers.
// Included by the checker file; depends on nothing else.
`ifndef SPRITE_ROW_RLE_DECODER_DEFINES_SVH
`define SPRITE_ROW_RLE_DECODER_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define SPRD_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define SPRD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sprd_pkg.sv -----
// Shared types and constants of the sprite row run-length decoder.
// Used by every module of the block; depends on nothing.
package sprd_pkg;

  localparam int unsigned COL_W = 9;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned ROW_W = 8;
  localparam int unsigned PIX_W = 8;

  localparam logic [COL_W-1:0] COL_MAX = 9'd511;
  localparam int unsigned TRANSP_BIT = 7;
  localparam int unsigned REPEAT_BIT = 6;

  typedef enum logic [1:0] {
    MODE_CTRL    = 2'd0,
    MODE_REPEAT  = 2'd1,
    MODE_LITERAL = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_last;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] x_start;
    logic [LEN_W-1:0] run_length;
    logic [PIX_W-1:0] pixel_value;
    logic             row_done;
  } run_t;

endpackage

// ----- rtl/core/sprd_in_stage.sv -----
// Input register of the sprite row decoder.
// Holds one coded word until the decode stage takes it; uses sprd_pkg.
module sprd_in_stage import sprd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     take,
  output logic     held_valid,
  output in_word_t held_word
);

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_word <= in_word;
    end
  end

endmodule

// ----- rtl/core/sprd_decode.sv -----
// Decode state and next-run logic of the sprite row decoder.
// Turns one held word into at most one run descriptor; uses sprd_pkg.
module sprd_decode import sprd_pkg::*; #(
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_word_t word,
  output logic     emit,
  output run_t     run
);

  mode_t            mode;
  mode_t            mode_next;
  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] count_next;
  logic [LEN_W-1:0] count_dec;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [LEN_W-1:0] len;
  logic [PIX_W-1:0] pix;
  logic [COL_W:0]   col_sum;
  logic [ROW_W:0]   row_inc;

  assign count_dec = count - 7'd1;
  assign col_sum   = {1'b0, column} + {{(COL_W+1-LEN_W){1'b0}}, len};
  assign row_inc   = {1'b0, row} + {{ROW_W{1'b0}}, 1'b1};

  always_comb begin
    emit       = 1'b0;
    len        = 7'd1;
    pix        = word.data_byte;
    mode_next  = mode;
    count_next = count;
    unique case (mode)
      MODE_REPEAT: begin
        emit       = (count != '0);
        len        = count;
        mode_next  = MODE_CTRL;
        count_next = '0;
      end
      MODE_LITERAL: begin
        emit       = 1'b1;
        count_next = count_dec;
        if (count_dec == '0) begin
          mode_next = MODE_CTRL;
        end
      end
      default: begin
        if (word.data_byte[TRANSP_BIT]) begin
          len        = word.data_byte[6:0];
          pix        = '0;
          mode_next  = MODE_CTRL;
          count_next = '0;
          emit       = (len != '0) && !word.row_last;
        end else if (word.data_byte[REPEAT_BIT]) begin
          mode_next  = MODE_REPEAT;
          count_next = {1'b0, word.data_byte[5:0]};
        end else begin
          count_next = {1'b0, word.data_byte[5:0]};
          mode_next  = (word.data_byte[5:0] != '0) ? MODE_LITERAL : MODE_CTRL;
        end
      end
    endcase

    column_next = column;
    if (emit) begin
      column_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
    end
    row_next = row;
    if (word.row_last) begin
      row_next    = (32'(row_inc) >= MAX_ROWS) ? '0 : row_inc[ROW_W-1:0];
      mode_next   = MODE_CTRL;
      count_next  = '0;
      column_next = '0;
    end
  end

  assign run.row_index   = row;
  assign run.x_start     = column;
  assign run.run_length  = len;
  assign run.pixel_value = pix;
  assign run.row_done    = word.row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_CTRL;
      count  <= '0;
      column <= '0;
      row    <= '0;
    end else if (fire) begin
      mode   <= mode_next;
      count  <= count_next;
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

// ----- rtl/core/sprd_out_stage.sv -----
// Result register of the sprite row decoder.
// Holds one run descriptor until the receiver takes it; uses sprd_pkg.
module sprd_out_stage import sprd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  run_t load_run,
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output run_t out_run
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      out_run <= load_run;
    end
  end

endmodule

// ----- rtl/core/sprite_row_rle_decoder.sv -----
// Sprite row run-length decoder: one coded byte in, at most one run out.
// An accepted byte passes through the input register and the result register to the output.
// Throughput is one byte per cycle while the output is not stalled; the decode step is combinational.
// A synchronous reset empties both registers and returns to row 0, column 0.
// Depends on sprd_pkg, sprd_in_stage, sprd_decode and sprd_out_stage.
module sprite_row_rle_decoder import sprd_pkg::*; #(
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             row_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] row_index,
  output logic [COL_W-1:0] x_start,
  output logic [LEN_W-1:0] run_length,
  output logic [PIX_W-1:0] pixel_value,
  output logic             row_done
);

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     out_ready;
  logic     fire;
  logic     emit;
  run_t     run;
  run_t     out_run;

  assign in_word.data_byte = data_byte;
  assign in_word.row_last  = row_last;
  assign fire              = held_valid && out_ready;

  sprd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (out_ready),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  sprd_decode #(.MAX_ROWS(MAX_ROWS)) u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (held_word),
    .emit (emit),
    .run  (run)
  );

  sprd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (fire && emit),
    .load_run   (run),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_run    (out_run)
  );

  assign row_index   = out_run.row_index;
  assign x_start     = out_run.x_start;
  assign run_length  = out_run.run_length;
  assign pixel_value = out_run.pixel_value;
  assign row_done    = out_run.row_done;

endmodule

// ----- rtl/core/sprd_checker.sv -----
// Port-level checks of the sprite row decoder, bound to the top level.
// Depends on sprd_pkg and sprite_row_rle_decoder_defines.svh.
`include "sprite_row_rle_decoder_defines.svh"
module sprd_checker import sprd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [7:0]       data_byte,
  input logic             row_last,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ROW_W-1:0] row_index,
  input logic [COL_W-1:0] x_start,
  input logic [LEN_W-1:0] run_length,
  input logic [PIX_W-1:0] pixel_value,
  input logic             row_done
);

  // An empty result register never holds back the input side.
  `SPRD_ASSERT_SAME(a_no_stall_empty, clk, rst, !out_valid, !in_stall,
    "input stalled while output empty")
  // A delivered run always covers at least one pixel.
  `SPRD_ASSERT_SAME(a_len_nonzero, clk, rst, out_valid, run_length != '0,
    "run of zero length")
  // A stalled run word stays on the port unchanged.
  `SPRD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(x_start) && $stable(run_length) && $stable(row_index) &&
    $stable(pixel_value) && $stable(row_done), "stalled run changed")
  // A stalled input word stays on the port unchanged.
  `SPRD_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall,
    in_valid && $stable(data_byte) && $stable(row_last), "stalled input changed")
  // The input side stalls only while a run waits in the result register.
  `SPRD_ASSERT_NEXT(a_stall_needs_run, clk, rst, in_stall, $past(out_valid),
    "stall without pending run")

endmodule

bind sprite_row_rle_decoder sprd_checker u_sprd_checker (.*);

// ----- verif/tb_sprite_row_rle_decoder.sv -----
// Testbench for sprite_row_rle_decoder: a scoreboard predicts the runs of the accepted
// words and checks the runs that come out, under random input gaps and random and long output stalls.
// Depends on sprd_pkg and the decoder RTL.
module tb_sprite_row_rle_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import sprd_pkg::*;

  localparam int ROW_COUNT   = 256;
  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 80;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] TRANSP_FLAG = 8'h80;
  localparam logic [7:0] REPEAT_FLAG = 8'h40;

  localparam logic [8:0] DIRECTED_WORDS [25] = '{
    {8'h80, 1'b0}, {8'h00, 1'b0}, {8'h40, 1'b0}, {8'h55, 1'b0}, {8'hFF, 1'b0},
    {8'h7F, 1'b0}, {8'hFF, 1'b0}, {8'h02, 1'b0}, {8'h00, 1'b0}, {8'hAA, 1'b0},
    {8'h81, 1'b1}, {8'h43, 1'b0}, {8'h12, 1'b1}, {8'h42, 1'b1}, {8'h05, 1'b0},
    {8'h01, 1'b0}, {8'h02, 1'b1}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
    {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'h41, 1'b0}, {8'h07, 1'b1}, {8'h00, 1'b1}
  };

  class run_scoreboard;
    mode_t            mode;
    logic [6:0]       remaining;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    run_t             runs_due[$];
    int               errors;
    int               reported;

    function new();
      mode      = MODE_CTRL;
      remaining = '0;
      column    = '0;
      row       = '0;
      errors    = 0;
      reported  = 0;
    endfunction

    function void add_run(logic [LEN_W-1:0] len, logic [PIX_W-1:0] pix, logic last);
      run_t           r;
      logic [COL_W:0] next_col;
      r.row_index   = row;
      r.x_start     = column;
      r.run_length  = len;
      r.pixel_value = pix;
      r.row_done    = last;
      runs_due.push_back(r);
      next_col = {1'b0, column} + {{(COL_W+1-LEN_W){1'b0}}, len};
      if (next_col > {1'b0, COL_MAX}) begin
        column = COL_MAX;
      end else begin
        column = next_col[COL_W-1:0];
      end
    endfunction

    function void note_word(logic [7:0] b, logic last);
      int next_row;
      case (mode)
        MODE_REPEAT: begin
          if (remaining != '0) add_run(remaining, b, last);
          mode      = MODE_CTRL;
          remaining = '0;
        end
        MODE_LITERAL: begin
          add_run(7'd1, b, last);
          remaining = remaining - 7'd1;
          if (remaining == '0) mode = MODE_CTRL;
        end
        default: begin
          if (b[TRANSP_BIT]) begin
            mode      = MODE_CTRL;
            remaining = '0;
            if (b[6:0] != '0 && !last) add_run(b[6:0], 8'd0, 1'b0);
          end else if (b[REPEAT_BIT]) begin
            mode      = MODE_REPEAT;
            remaining = {1'b0, b[5:0]};
          end else begin
            remaining = {1'b0, b[5:0]};
            if (remaining != '0) begin
              mode = MODE_LITERAL;
            end else begin
              mode = MODE_CTRL;
            end
          end
        end
      endcase
      if (last) begin
        next_row = int'(row) + 1;
        if (next_row >= ROW_COUNT) next_row = 0;
        row       = next_row[ROW_W-1:0];
        mode      = MODE_CTRL;
        remaining = '0;
        column    = '0;
      end
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (runs_due.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("unexpected run: row %0d x %0d len %0d pix %0d done %0b",
                   got.row_index, got.x_start, got.run_length, got.pixel_value,
                   got.row_done);
        end
        return;
      end
      want = runs_due.pop_front();
      if (got.row_index !== want.row_index || got.x_start !== want.x_start ||
          got.run_length !== want.run_length || got.pixel_value !== want.pixel_value ||
          got.row_done !== want.row_done) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("run mismatch: expected row %0d x %0d len %0d pix %0d done %0b",
                   want.row_index, want.x_start, want.run_length, want.pixel_value,
                   want.row_done);
          $display("              got      row %0d x %0d len %0d pix %0d done %0b",
                   got.row_index, got.x_start, got.run_length, got.pixel_value,
                   got.row_done);
        end
      end
    endfunction

    function int pending();
      return runs_due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = 8'd0;
  logic             row_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] x_start;
  logic [LEN_W-1:0] run_length;
  logic [PIX_W-1:0] pixel_value;
  logic             row_done;

  bit              quiet = 1'b0;
  bit              long_hold = 1'b0;
  int              sent = 0;
  int              cycles = 0;
  logic [7:0]      row_bytes[$];
  run_scoreboard   sb = new();

  sprite_row_rle_decoder #(.MAX_ROWS(ROW_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .row_last(row_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_index(row_index),
    .x_start(x_start),
    .run_length(run_length),
    .pixel_value(pixel_value),
    .row_done(row_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    run_t seen;
    if (!rst && in_valid && !in_stall) sb.note_word(data_byte, row_last);
    if (!rst && out_valid && !out_stall) begin
      seen.row_index   = row_index;
      seen.x_start     = x_start;
      seen.run_length  = run_length;
      seen.pixel_value = pixel_value;
      seen.row_done    = row_done;
      sb.check_run(seen);
    end
  end

  always @(posedge clk) begin : rx_side
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 33);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    row_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(99) < 33) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_row();
    foreach (row_bytes[i]) send_word(row_bytes[i], i == row_bytes.size() - 1);
  endtask

  task automatic build_row();
    int codes;
    int cnt;
    row_bytes.delete();
    if ($urandom_range(99) < 8) begin
      cnt = $urandom_range(1, 12);
      repeat (cnt) row_bytes.push_back(8'($urandom_range(255)));
    end else begin
      codes = $urandom_range(0, 5);
      repeat (codes) begin
        case ($urandom_range(2))
          0: row_bytes.push_back(TRANSP_FLAG | 8'($urandom_range(127)));
          1: begin
            row_bytes.push_back(REPEAT_FLAG | 8'($urandom_range(63)));
            row_bytes.push_back(8'($urandom_range(255)));
          end
          default: begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 6);
            row_bytes.push_back(8'(cnt));
            repeat (cnt) row_bytes.push_back(8'($urandom_range(255)));
          end
        endcase
      end
      if (row_bytes.size() == 0) row_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(row_bytes.size() - 1)) void'(row_bytes.pop_back());
      end
    end
  endtask

  initial begin : stimulus
    bit pressed;
    bit drained;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_WORDS[i]) send_word(DIRECTED_WORDS[i][8:1], DIRECTED_WORDS[i][0]);
    while (sent < ITEM_TARGET) begin
      if (!pressed && sent >= 400) begin
        pressed = 1'b1;
        long_hold <= 1'b1;
      end
      if (!drained && sent >= 1000) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end
      quiet <= (sent >= 1300 && sent < 1600);
      build_row();
      send_row();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sprd_pkg.sv
rtl/core/sprd_in_stage.sv
rtl/core/sprd_decode.sv
rtl/core/sprd_out_stage.sv
rtl/core/sprite_row_rle_decoder.sv
rtl/core/sprd_checker.sv
verif/tb_sprite_row_rle_decoder.sv
